// ===== design/fdsc_pkg.sv =====
// shared types, constants and helpers for the fan duty slowdown controller
package fdsc_pkg;

    localparam int DUTY_W  = 10;
    localparam int RPM_W   = 18;
    localparam int SLOW_W  = 17;
    localparam int PULSE_W = 13;
    localparam int LEVEL_W = 10;
    localparam int MODE_W  = 2;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    localparam logic [DUTY_W-1:0]  DUTY_FULL = 10'd1000;
    localparam logic [RPM_W-1:0]   RPM_MAX   = '1;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

    localparam logic [DUTY_W-1:0] MIN_RUN_RESET    = 10'd230;
    localparam logic [DUTY_W-1:0] STARTUP_RESET    = 10'd300;
    localparam logic [RPM_W-1:0]  STARTUP_RPM_RESET = 18'd100;
    localparam logic [SLOW_W-1:0] SLOW_DELAY_RESET = 17'd90000;

    typedef enum logic [MODE_W-1:0] {
        EV_TICK    = 2'd0,
        EV_TACH    = 2'd1,
        EV_REQUEST = 2'd2
    } event_t;

    typedef enum logic [1:0] {
        FAN_OFF     = 2'd0,
        FAN_STARTUP = 2'd1,
        FAN_RUNNING = 2'd2
    } fan_state_t;

    typedef enum logic [1:0] {
        REG_MIN_RUN     = 2'd0,
        REG_STARTUP     = 2'd1,
        REG_STARTUP_RPM = 2'd2,
        REG_SLOW_DELAY  = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [DUTY_W-1:0] min_running_duty;
        logic [DUTY_W-1:0] startup_duty;
        logic [RPM_W-1:0]  min_startup_rpm;
        logic [SLOW_W-1:0] slowdown_delay_ms;
    } cfg_t;

    function automatic logic [DUTY_W-1:0] clamp_duty(input logic [DUTY_W-1:0] d);
        return (d > DUTY_FULL) ? DUTY_FULL : d;
    endfunction

endpackage

// ===== design/fdsc_if.sv =====
// event and result channel interfaces
interface fdsc_evt_if;
    import fdsc_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [DUTY_W-1:0] requested_duty;

    modport source (output valid, mode, requested_duty, input ready);
    modport sink (input valid, mode, requested_duty, output ready);
endinterface

interface fdsc_res_if;
    import fdsc_pkg::*;

    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] pwm_level;
    logic               power_on;
    logic [1:0]         fan_state;
    logic [DUTY_W-1:0]  current_duty;
    logic               rpm_valid;
    logic               fan_on;
    logic               fan_spinning;
    logic [RPM_W-1:0]   rpm;

    modport source (output valid, pwm_level, power_on, fan_state, current_duty, rpm_valid,
                    fan_on, fan_spinning, rpm, input ready);
    modport sink (input valid, pwm_level, power_on, fan_state, current_duty, rpm_valid,
                  fan_on, fan_spinning, rpm, output ready);
endinterface

// ===== design/fdsc_regs.sv =====
// apb configuration registers
module fdsc_regs (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [fdsc_pkg::ADDR_W-1:0] paddr,
    input  logic [fdsc_pkg::DATA_W-1:0] pwdata,
    output logic [fdsc_pkg::DATA_W-1:0] prdata,
    output logic                      pready,
    output fdsc_pkg::cfg_t            cfg
);
    import fdsc_pkg::*;

    cfg_t       cfg_reg;
    reg_index_t index;
    logic       wr_en;

    assign index  = reg_index_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_running_duty  <= MIN_RUN_RESET;
            cfg_reg.startup_duty      <= STARTUP_RESET;
            cfg_reg.min_startup_rpm   <= STARTUP_RPM_RESET;
            cfg_reg.slowdown_delay_ms <= SLOW_DELAY_RESET;
        end
        else if (wr_en)
        begin
            unique case (index)
                REG_MIN_RUN:     cfg_reg.min_running_duty  <= pwdata[DUTY_W-1:0];
                REG_STARTUP:     cfg_reg.startup_duty      <= pwdata[DUTY_W-1:0];
                REG_STARTUP_RPM: cfg_reg.min_startup_rpm   <= pwdata[RPM_W-1:0];
                REG_SLOW_DELAY:  cfg_reg.slowdown_delay_ms <= pwdata[SLOW_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            REG_MIN_RUN:     prdata = DATA_W'(cfg_reg.min_running_duty);
            REG_STARTUP:     prdata = DATA_W'(cfg_reg.startup_duty);
            REG_STARTUP_RPM: prdata = DATA_W'(cfg_reg.min_startup_rpm);
            REG_SLOW_DELAY:  prdata = DATA_W'(cfg_reg.slowdown_delay_ms);
            default:         prdata = '0;
        endcase
    end

endmodule

// ===== design/fan_duty_slowdown_controller_top.sv =====
// fan duty controller top level: event handling, slowdown timer, rpm window, result register
// One event (1 ms tick, tach edge or duty request) is accepted every clock cycle unless a
// held result stalls it, and yields exactly one result, which appears in the output register
// on the cycle after the request is taken and stays there until the sink takes it; while it
// waits, the next request is still accepted if the sink is ready in the same cycle. A
// single pass of state update and duty to PWM scaling (one constant multiplier) lies
// between the state and result registers. There is no clearing pass after reset.
module fan_duty_slowdown_controller_top #(
    parameter int PWM_BITS      = 10,
    parameter int RPM_WINDOW_MS = 1000
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fdsc_pkg::ADDR_W-1:0] paddr,
    input  logic [fdsc_pkg::DATA_W-1:0] pwdata,
    output logic [fdsc_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    fdsc_evt_if.sink                    evt,
    fdsc_res_if.source                  res
);
    import fdsc_pkg::*;

    localparam int WIN_W   = $clog2(RPM_WINDOW_MS);
    localparam logic [WIN_W-1:0] WIN_LAST = WIN_W'(RPM_WINDOW_MS - 1);
    localparam int FACT    = 60000 / RPM_WINDOW_MS;
    localparam int FACT_W  = $clog2(FACT + 1);
    localparam int REVS_W  = PULSE_W - 1;
    localparam int RAW_W   = REVS_W + FACT_W + 1;
    localparam int SHIFT   = 20;
    localparam int SCALE_W = PWM_BITS + 11;
    localparam logic [SCALE_W-1:0] SCALE_M =
        SCALE_W'(((64'd1 << (SHIFT + PWM_BITS)) + 64'd999) / 64'd1000);
    localparam int PROD_W  = DUTY_W + SCALE_W;
    localparam int Q_W     = PWM_BITS + 1;
    localparam int EXT_W   = (PWM_BITS > LEVEL_W) ? PWM_BITS : LEVEL_W;

    cfg_t cfg;

    fan_state_t          state_reg, state_next;
    logic [DUTY_W-1:0]   set_duty_reg, set_duty_next;
    logic [DUTY_W-1:0]   queued_duty_reg, queued_duty_next;
    logic                pending_reg, pending_next;
    logic [SLOW_W-1:0]   slow_reg, slow_next;
    logic [WIN_W-1:0]    window_reg, window_next;
    logic [PULSE_W-1:0]  pulse_reg, pulse_next;
    logic [RPM_W-1:0]    last_rpm_reg, last_rpm_next;
    logic [PWM_BITS-1:0] pwm_reg, pwm_next;
    logic                power_reg, power_next;

    logic                res_valid_reg;
    logic [LEVEL_W-1:0]  level_reg;
    logic                power_out_reg;
    logic [1:0]          state_out_reg;
    logic [DUTY_W-1:0]   duty_out_reg;
    logic                rpm_valid_reg, fan_on_reg, spin_reg;
    logic [RPM_W-1:0]    rpm_out_reg;

    logic                accept;
    logic [DUTY_W-1:0]   req_c, minr, corr, drive_val, scale_duty;
    logic                drive_en, turn_off, hold;
    logic                rpm_valid_c, fan_on_c, spin_c;
    logic [RPM_W-1:0]    rpm_c, rpm_sat;
    logic [REVS_W-1:0]   revs;
    logic [RAW_W-1:0]    rpm_raw;
    logic [SLOW_W-1:0]   slow_inc;
    logic [PROD_W-1:0]   scale_prod;
    logic [Q_W-1:0]      scale_q;
    logic [PWM_BITS-1:0] pwm_new;
    logic [EXT_W-1:0]    pwm_ext;
    logic [LEVEL_W-1:0]  level_c;

    fdsc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign evt.ready = !res_valid_reg || res.ready;
    assign accept    = evt.valid && evt.ready;

    assign req_c    = clamp_duty(evt.requested_duty);
    assign minr     = clamp_duty(cfg.min_running_duty);
    assign corr     = (req_c > minr) ? req_c : minr;
    assign revs     = pulse_reg[PULSE_W-1:1];
    assign rpm_raw  = RAW_W'(revs) * RAW_W'(FACT);
    assign rpm_sat  = (rpm_raw > RAW_W'(RPM_MAX)) ? RPM_MAX : rpm_raw[RPM_W-1:0];
    assign slow_inc = (slow_reg == '1) ? slow_reg : slow_reg + 1'b1;

    always_comb
    begin
        state_next       = state_reg;
        set_duty_next    = set_duty_reg;
        queued_duty_next = queued_duty_reg;
        pending_next     = pending_reg;
        slow_next        = slow_reg;
        window_next      = window_reg;
        pulse_next       = pulse_reg;
        last_rpm_next    = last_rpm_reg;
        power_next       = power_reg;
        drive_en         = 1'b0;
        drive_val        = set_duty_reg;
        turn_off         = 1'b0;
        hold             = 1'b0;
        rpm_valid_c      = 1'b0;
        fan_on_c         = 1'b0;
        spin_c           = 1'b0;
        rpm_c            = '0;
        if (accept)
        begin
            case (evt.mode)
                EV_TICK:
                begin
                    if (window_reg == WIN_LAST)
                    begin
                        window_next   = '0;
                        pulse_next    = '0;
                        last_rpm_next = rpm_sat;
                        rpm_valid_c   = 1'b1;
                        if (state_reg != FAN_OFF)
                        begin
                            fan_on_c = 1'b1;
                            if (revs != '0)
                            begin
                                spin_c = 1'b1;
                                rpm_c  = rpm_sat;
                            end
                        end
                    end
                    else
                    begin
                        window_next = window_reg + 1'b1;
                    end
                    if (pending_reg)
                    begin
                        slow_next = slow_inc;
                        if (slow_inc >= cfg.slowdown_delay_ms)
                        begin
                            if (queued_duty_reg == '0)
                            begin
                                turn_off      = 1'b1;
                                state_next    = FAN_OFF;
                                set_duty_next = '0;
                                power_next    = 1'b0;
                            end
                            else
                            begin
                                drive_en  = 1'b1;
                                drive_val = queued_duty_reg;
                            end
                            queued_duty_next = '0;
                            pending_next     = 1'b0;
                        end
                    end
                end
                EV_TACH:
                begin
                    if (pulse_reg != '1)
                    begin
                        pulse_next = pulse_reg + 1'b1;
                    end
                end
                EV_REQUEST:
                begin
                    if (req_c == '0)
                    begin
                        if (state_reg != FAN_OFF)
                        begin
                            pending_next = 1'b1;
                            if (!(pending_reg && queued_duty_reg == '0))
                            begin
                                queued_duty_next = '0;
                                slow_next        = '0;
                            end
                        end
                    end
                    else
                    begin
                        if (last_rpm_reg < cfg.min_startup_rpm)
                        begin
                            state_next = FAN_STARTUP;
                        end
                        else
                        begin
                            state_next = FAN_RUNNING;
                            hold = (corr == set_duty_reg) && pending_reg
                                   && (req_c == queued_duty_reg);
                        end
                        if (!hold)
                        begin
                            if (corr > set_duty_reg)
                            begin
                                drive_en  = 1'b1;
                                drive_val = corr;
                            end
                            else
                            begin
                                pending_next = 1'b1;
                                if (!(pending_reg && queued_duty_reg == corr))
                                begin
                                    queued_duty_next = corr;
                                    slow_next        = '0;
                                end
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
        if (drive_en)
        begin
            power_next    = 1'b1;
            set_duty_next = drive_val;
        end
    end

    // duty in tenths of percent to pwm compare value, via a rounded-up fixed-point reciprocal of 1000
    assign scale_duty = (state_next == FAN_STARTUP) ? clamp_duty(cfg.startup_duty) : drive_val;
    assign scale_prod = PROD_W'(scale_duty) * PROD_W'(SCALE_M);
    assign scale_q    = scale_prod[SHIFT +: Q_W];
    assign pwm_new    = scale_q[PWM_BITS] ? '1 : scale_q[PWM_BITS-1:0];

    always_comb
    begin
        if (drive_en)
        begin
            pwm_next = pwm_new;
        end
        else if (turn_off)
        begin
            pwm_next = '0;
        end
        else
        begin
            pwm_next = pwm_reg;
        end
    end

    assign pwm_ext = EXT_W'(pwm_next);
    assign level_c = (pwm_ext > EXT_W'(LEVEL_MAX)) ? LEVEL_MAX : pwm_ext[LEVEL_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= FAN_OFF;
            set_duty_reg    <= '0;
            queued_duty_reg <= '0;
            pending_reg     <= 1'b0;
            slow_reg        <= '0;
            window_reg      <= '0;
            pulse_reg       <= '0;
            last_rpm_reg    <= '0;
            pwm_reg         <= '0;
            power_reg       <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            set_duty_reg    <= set_duty_next;
            queued_duty_reg <= queued_duty_next;
            pending_reg     <= pending_next;
            slow_reg        <= slow_next;
            window_reg      <= window_next;
            pulse_reg       <= pulse_next;
            last_rpm_reg    <= last_rpm_next;
            pwm_reg         <= pwm_next;
            power_reg       <= power_next;
            if (accept)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            level_reg     <= level_c;
            power_out_reg <= power_next;
            state_out_reg <= state_next;
            duty_out_reg  <= set_duty_next;
            rpm_valid_reg <= rpm_valid_c;
            fan_on_reg    <= fan_on_c;
            spin_reg      <= spin_c;
            rpm_out_reg   <= rpm_c;
        end
    end

    assign res.valid        = res_valid_reg;
    assign res.pwm_level    = level_reg;
    assign res.power_on     = power_out_reg;
    assign res.fan_state    = state_out_reg;
    assign res.current_duty = duty_out_reg;
    assign res.rpm_valid    = rpm_valid_reg;
    assign res.fan_on       = fan_on_reg;
    assign res.fan_spinning = spin_reg;
    assign res.rpm          = rpm_out_reg;

endmodule
